FILE: hdl/best_detection_box_select_defines.svh
// ----------------------------------------------------------------------------
// best_detection_box_select_defines.svh
// assertion macros shared by the checker of the box selector
// ----------------------------------------------------------------------------
`ifndef BEST_DETECTION_BOX_SELECT_DEFINES_SVH
`define BEST_DETECTION_BOX_SELECT_DEFINES_SVH

// property checked on every clock edge outside reset
`define BDBS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BDBS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/bdbs_pkg.sv
// ----------------------------------------------------------------------------
// bdbs_pkg
// shared types and constants of the best detection box selector
// ----------------------------------------------------------------------------
package bdbs_pkg;

   localparam int CONF_W      = 16;
   localparam int PAD_W       = 11;
   localparam int SCALE_W     = 16;
   localparam int XY_W        = 15;
   localparam int WH_W        = 16;
   localparam int FRAC_W      = 16;  // mapped coordinates are Q.16 before truncation
   localparam int SUBPIX_W    = 4;   // model coordinates are Q11.4
   localparam int C2_W        = 2 * CONF_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int RSP_DATA_W  = 80;

   localparam logic [CONF_W-1:0]  MIN_CONF_RESET      = 16'd16384;
   localparam logic [PAD_W-1:0]   PAD_RESET           = 11'd0;
   localparam logic [SCALE_W-1:0] INVERSE_SCALE_RESET = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_CONF      = 2'd0,
      CSR_PAD_LEFT      = 2'd1,
      CSR_PAD_TOP       = 2'd2,
      CSR_INVERSE_SCALE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CONF_W-1:0]  min_conf;
      logic [PAD_W-1:0]   pad_left;
      logic [PAD_W-1:0]   pad_top;
      logic [SCALE_W-1:0] inverse_scale;
   } cfg_type;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic signed [WH_W-1:0] rect_h;
      logic signed [WH_W-1:0] rect_w;
      logic [XY_W-1:0]        rect_y;
      logic [XY_W-1:0]        rect_x;
      logic [CONF_W-1:0]      confidence;
   } rsp_type;

   // queue word: last, qual, conf, four corners, two partial products
   function automatic int entry_width(int coord_bits);
      return 2 + CONF_W + 4 * coord_bits + 2 * (C2_W + coord_bits);
   endfunction

endpackage

FILE: hdl/best_detection_box_select.sv
// ----------------------------------------------------------------------------
// best_detection_box_select
// picks the strongest detection of a frame and maps it to original pixels
// ----------------------------------------------------------------------------
// req_* carries one candidate box per word, req_tlast on the last box of a
// frame. rsp_* carries one word per frame: rsp_tuser is the found flag and
// rsp_tdata the confidence and rectangle, all zero when nothing qualified.
// csr_* writes the threshold, padding and inverse scale; the user must write
// them only while no frame is in flight, as the block does not enforce it.
// Throughput is one box per cycle inside a frame while req_tready is high.
// After the last box the back part runs the three mapping steps (difference,
// multiply, saturate) and does not drain the queue meanwhile.
// The edge that accepts the last box loads the first of three ranking
// product stages; then come the queue write, the compare and the three
// mapping steps, after which rsp_tvalid rises.
// A stalled rsp_tready holds the result word; boxes keep coming in until the
// queue and the three product stages together hold 8 words, then req_tready
// drops.
// Synchronous reset restores the register defaults, empties the queue and
// clears the running best box.
// ----------------------------------------------------------------------------
module best_detection_box_select #(
   parameter int COORD_BITS = 16,
   localparam int REQ_BITS  = 4 * COORD_BITS + bdbs_pkg::CONF_W,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // box_x1, box_y1, box_x2, box_y2, box_conf
   input  logic [REQ_W-1:0]                    req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // confidence, rect_x, rect_y, rect_w, rect_h
   output logic [bdbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bdbs_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ENTRY_W = bdbs_pkg::entry_width(COORD_BITS);
   localparam int CNT_W   = $clog2(bdbs_pkg::QUEUE_DEPTH + 1);

   bdbs_pkg::cfg_type   cfg_ff, cfg_in;
   logic                push_valid;
   logic [ENTRY_W-1:0]  push_data;
   logic                queue_pop;
   logic [ENTRY_W-1:0]  queue_data;
   logic                queue_empty;
   logic [CNT_W-1:0]    queue_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (bdbs_pkg::csr_index_type'(csr_index))
            bdbs_pkg::CSR_MIN_CONF:      cfg_in.min_conf = csr_data;
            bdbs_pkg::CSR_PAD_LEFT:      cfg_in.pad_left = csr_data[bdbs_pkg::PAD_W-1:0];
            bdbs_pkg::CSR_PAD_TOP:       cfg_in.pad_top = csr_data[bdbs_pkg::PAD_W-1:0];
            bdbs_pkg::CSR_INVERSE_SCALE: cfg_in.inverse_scale = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_conf      <= bdbs_pkg::MIN_CONF_RESET;
         cfg_ff.pad_left      <= bdbs_pkg::PAD_RESET;
         cfg_ff.pad_top       <= bdbs_pkg::PAD_RESET;
         cfg_ff.inverse_scale <= bdbs_pkg::INVERSE_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bdbs_front #(
      .COORD_BITS (COORD_BITS),
      .DEPTH      (bdbs_pkg::QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_fields  (req_tdata[REQ_BITS-1:0]),
      .req_tlast   (req_tlast),
      .min_conf    (cfg_ff.min_conf),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   bdbs_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (bdbs_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   bdbs_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_found   (rsp_tuser),
      .rsp_data    (rsp_tdata)
   );

endmodule

FILE: hdl/bdbs_front.sv
// ----------------------------------------------------------------------------
// bdbs_front
// accepts candidate boxes, qualifies them and forms the ranking products
// ----------------------------------------------------------------------------
module bdbs_front #(
   parameter int COORD_BITS = 16,
   parameter int DEPTH      = 8,
   localparam int ENTRY_W   = bdbs_pkg::entry_width(COORD_BITS),
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [4*COORD_BITS+bdbs_pkg::CONF_W-1:0] req_fields,
   input  logic                          req_tlast,
   input  logic [bdbs_pkg::CONF_W-1:0]   min_conf,
   input  logic [CNT_W-1:0]              queue_count,
   output logic                          push_valid,
   output logic [ENTRY_W-1:0]            push_data
);

   localparam int CB   = COORD_BITS;
   localparam int AW   = 2 * CB;
   localparam int PW   = bdbs_pkg::C2_W + CB;

   typedef struct packed {
      logic                             last;
      logic                             qual;
      logic [bdbs_pkg::CONF_W-1:0]      conf;
      logic signed [CB-1:0]             x1;
      logic signed [CB-1:0]             y1;
      logic signed [CB-1:0]             x2;
      logic signed [CB-1:0]             y2;
      logic [PW-1:0]                    p_lo;
      logic [PW-1:0]                    p_hi;
   } entry_type;

   typedef struct packed {
      logic                             last;
      logic                             qual;
      logic [bdbs_pkg::CONF_W-1:0]      conf;
      logic signed [CB-1:0]             x1;
      logic signed [CB-1:0]             y1;
      logic signed [CB-1:0]             x2;
      logic signed [CB-1:0]             y2;
   } box_type;

   logic                     accept;
   logic signed [CB-1:0]     in_x1, in_y1, in_x2, in_y2;
   logic [bdbs_pkg::CONF_W-1:0] in_conf;
   logic signed [CB:0]       w, h;
   logic [CB-1:0]            mag_w, mag_h;
   logic                     pos_area;
   logic [CNT_W:0]           used;

   logic                     s1_valid_ff, s1_valid_in;
   box_type                  s1_box_ff, s1_box_in;
   logic [CB-1:0]            s1_mag_w_ff, s1_mag_w_in;
   logic [CB-1:0]            s1_mag_h_ff, s1_mag_h_in;

   logic                     s2_valid_ff, s2_valid_in;
   box_type                  s2_box_ff;
   logic [AW-1:0]            s2_area_ff, s2_area_in;
   logic [bdbs_pkg::C2_W-1:0] s2_c2_ff, s2_c2_in;

   logic                     s3_valid_ff, s3_valid_in;
   box_type                  s3_box_ff;
   logic [PW-1:0]            s3_p_lo_ff, s3_p_lo_in;
   logic [PW-1:0]            s3_p_hi_ff, s3_p_hi_in;

   entry_type                entry;

   assign in_x1   = req_fields[CB-1:0];
   assign in_y1   = req_fields[2*CB-1:CB];
   assign in_x2   = req_fields[3*CB-1:2*CB];
   assign in_y2   = req_fields[4*CB-1:3*CB];
   assign in_conf = req_fields[4*CB+bdbs_pkg::CONF_W-1:4*CB];

   // room in the queue for every word already in the pipe
   assign used = (CNT_W+1)'(queue_count) + (CNT_W+1)'(s1_valid_ff)
               + (CNT_W+1)'(s2_valid_ff) + (CNT_W+1)'(s3_valid_ff);
   assign req_tready = used < (CNT_W+1)'(DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      w        = {in_x2[CB-1], in_x2} - {in_x1[CB-1], in_x1};
      h        = {in_y2[CB-1], in_y2} - {in_y1[CB-1], in_y1};
      mag_w    = w[CB] ? CB'(-w) : w[CB-1:0];
      mag_h    = h[CB] ? CB'(-h) : h[CB-1:0];
      pos_area = (w != '0) && (h != '0) && (w[CB] == h[CB]);

      s1_valid_in    = accept;
      s1_box_in.last = req_tlast;
      s1_box_in.qual = (in_conf > min_conf) && pos_area;
      s1_box_in.conf = in_conf;
      s1_box_in.x1   = in_x1;
      s1_box_in.y1   = in_y1;
      s1_box_in.x2   = in_x2;
      s1_box_in.y2   = in_y2;
      s1_mag_w_in    = mag_w;
      s1_mag_h_in    = mag_h;

      s2_valid_in = s1_valid_ff;
      s2_area_in  = s1_mag_w_ff * s1_mag_h_ff;
      s2_c2_in    = s1_box_ff.conf * s1_box_ff.conf;

      // metric is split so that no product is wider than 32 by COORD_BITS
      s3_valid_in = s2_valid_ff;
      s3_p_lo_in  = s2_c2_ff * s2_area_ff[CB-1:0];
      s3_p_hi_in  = s2_c2_ff * s2_area_ff[AW-1:CB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_box_ff   <= s1_box_in;
      s1_mag_w_ff <= s1_mag_w_in;
      s1_mag_h_ff <= s1_mag_h_in;
      s2_box_ff   <= s1_box_ff;
      s2_area_ff  <= s2_area_in;
      s2_c2_ff    <= s2_c2_in;
      s3_box_ff   <= s2_box_ff;
      s3_p_lo_ff  <= s3_p_lo_in;
      s3_p_hi_ff  <= s3_p_hi_in;
   end

   always_comb begin
      entry.last = s3_box_ff.last;
      entry.qual = s3_box_ff.qual;
      entry.conf = s3_box_ff.conf;
      entry.x1   = s3_box_ff.x1;
      entry.y1   = s3_box_ff.y1;
      entry.x2   = s3_box_ff.x2;
      entry.y2   = s3_box_ff.y2;
      entry.p_lo = s3_p_lo_ff;
      entry.p_hi = s3_p_hi_ff;
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = entry;

endmodule

FILE: hdl/bdbs_fifo.sv
// ----------------------------------------------------------------------------
// bdbs_fifo
// short register queue between the front and the back part
// ----------------------------------------------------------------------------
module bdbs_fifo #(
   parameter int WIDTH   = 8,
   parameter int DEPTH   = 8,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // depth is a power of two, so the pointers wrap by themselves
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

FILE: hdl/bdbs_back.sv
// ----------------------------------------------------------------------------
// bdbs_back
// keeps the best box of a frame and maps it back to original pixels
// ----------------------------------------------------------------------------
module bdbs_back #(
   parameter int COORD_BITS = 16,
   localparam int ENTRY_W   = bdbs_pkg::entry_width(COORD_BITS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bdbs_pkg::cfg_type                cfg,
   input  logic                             queue_empty,
   input  logic [ENTRY_W-1:0]               queue_data,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [bdbs_pkg::RSP_DATA_W-1:0]  rsp_data
);

   localparam int CB  = COORD_BITS;
   localparam int PW  = bdbs_pkg::C2_W + CB;
   localparam int MW  = bdbs_pkg::C2_W + 2 * CB;
   localparam int DW  = ((CB > 16) ? CB : 16) + 1;
   localparam int QW  = DW + bdbs_pkg::SCALE_W + 1;
   localparam int VW  = QW - bdbs_pkg::FRAC_W;
   localparam logic [VW-2:0]        XY_MAX = (VW-1)'(32767);
   localparam logic signed [VW-1:0] WH_MAX = VW'(32767);
   localparam logic signed [VW-1:0] WH_MIN = VW'(-32768);

   typedef struct packed {
      logic                             last;
      logic                             qual;
      logic [bdbs_pkg::CONF_W-1:0]      conf;
      logic signed [CB-1:0]             x1;
      logic signed [CB-1:0]             y1;
      logic signed [CB-1:0]             x2;
      logic signed [CB-1:0]             y2;
      logic [PW-1:0]                    p_lo;
      logic [PW-1:0]                    p_hi;
   } entry_type;

   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,
      ST_DIFF = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_SAT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   entry_type   entry;
   logic [MW-1:0] metric;
   logic        better;
   logic        out_free;

   logic [MW-1:0]                best_metric_ff, best_metric_in;
   logic signed [CB-1:0]         best_left_ff, best_left_in;
   logic signed [CB-1:0]         best_top_ff, best_top_in;
   logic signed [CB-1:0]         best_right_ff, best_right_in;
   logic signed [CB-1:0]         best_bottom_ff, best_bottom_in;
   logic [bdbs_pkg::CONF_W-1:0]  best_conf_ff, best_conf_in;
   logic                         have_best_ff, have_best_in;

   logic                         found_ff;
   logic [bdbs_pkg::CONF_W-1:0]  conf_ff;
   logic signed [DW-1:0]         left_d_ff, top_d_ff, w_d_ff, h_d_ff;
   logic signed [QW-1:0]         left_q_ff, top_q_ff, w_q_ff, h_q_ff;
   logic signed [bdbs_pkg::SCALE_W:0] scale_s;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   bdbs_pkg::rsp_type            rsp_word_ff, rsp_word_in;

   // Q.16 to clamped, truncated 15-bit position
   function automatic logic [bdbs_pkg::XY_W-1:0] to_pos(logic signed [QW-1:0] q);
      logic [VW-2:0] v;
      v = q[QW-2:bdbs_pkg::FRAC_W];
      if (q[QW-1]) begin
         return '0;
      end else if (v > XY_MAX) begin
         return XY_MAX[bdbs_pkg::XY_W-1:0];
      end
      return v[bdbs_pkg::XY_W-1:0];
   endfunction

   // Q.16 to signed 16-bit, truncated toward zero and saturated
   function automatic logic [bdbs_pkg::WH_W-1:0] to_signed16(logic signed [QW-1:0] q);
      logic signed [QW-1:0] adj;
      logic signed [VW-1:0] v;
      adj = q + $signed({{(QW-bdbs_pkg::FRAC_W){1'b0}}, {bdbs_pkg::FRAC_W{q[QW-1]}}});
      v   = adj[QW-1:bdbs_pkg::FRAC_W];
      if (v > WH_MAX) begin
         return WH_MAX[bdbs_pkg::WH_W-1:0];
      end else if (v < WH_MIN) begin
         return WH_MIN[bdbs_pkg::WH_W-1:0];
      end
      return v[bdbs_pkg::WH_W-1:0];
   endfunction

   assign entry    = queue_data;
   assign metric   = (MW'(entry.p_hi) << CB) + MW'(entry.p_lo);
   assign better   = entry.qual && (metric > best_metric_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scale_s  = $signed({1'b0, cfg.inverse_scale});

   always_comb begin
      state_in       = state_ff;
      queue_pop      = 1'b0;
      best_metric_in = best_metric_ff;
      best_left_in   = best_left_ff;
      best_top_in    = best_top_ff;
      best_right_in  = best_right_ff;
      best_bottom_in = best_bottom_ff;
      best_conf_in   = best_conf_ff;
      have_best_in   = have_best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_RUN: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               if (better) begin
                  best_metric_in = metric;
                  best_left_in   = entry.x1;
                  best_top_in    = entry.y1;
                  best_right_in  = entry.x2;
                  best_bottom_in = entry.y2;
                  best_conf_in   = entry.conf;
                  have_best_in   = 1'b1;
               end
               if (entry.last) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            // winner is captured below, so the frame state clears here
            best_metric_in = '0;
            best_left_in   = '0;
            best_top_in    = '0;
            best_right_in  = '0;
            best_bottom_in = '0;
            best_conf_in   = '0;
            have_best_in   = 1'b0;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_word_in = '0;
      if (found_ff) begin
         rsp_word_in.confidence = conf_ff;
         rsp_word_in.rect_x     = to_pos(left_q_ff);
         rsp_word_in.rect_y     = to_pos(top_q_ff);
         rsp_word_in.rect_w     = to_signed16(w_q_ff);
         rsp_word_in.rect_h     = to_signed16(h_q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         rsp_valid_ff   <= 1'b0;
         have_best_ff   <= 1'b0;
         best_metric_ff <= '0;
         best_left_ff   <= '0;
         best_top_ff    <= '0;
         best_right_ff  <= '0;
         best_bottom_ff <= '0;
         best_conf_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         have_best_ff   <= have_best_in;
         best_metric_ff <= best_metric_in;
         best_left_ff   <= best_left_in;
         best_top_ff    <= best_top_in;
         best_right_ff  <= best_right_in;
         best_bottom_ff <= best_bottom_in;
         best_conf_ff   <= best_conf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         found_ff  <= have_best_ff;
         conf_ff   <= best_conf_ff;
         left_d_ff <= DW'(best_left_ff)
                    - $signed(DW'({cfg.pad_left, {bdbs_pkg::SUBPIX_W{1'b0}}}));
         top_d_ff  <= DW'(best_top_ff)
                    - $signed(DW'({cfg.pad_top, {bdbs_pkg::SUBPIX_W{1'b0}}}));
         w_d_ff    <= DW'(best_right_ff) - DW'(best_left_ff);
         h_d_ff    <= DW'(best_bottom_ff) - DW'(best_top_ff);
      end
      if (state_ff == ST_MUL) begin
         left_q_ff <= left_d_ff * scale_s;
         top_q_ff  <= top_d_ff * scale_s;
         w_q_ff    <= w_d_ff * scale_s;
         h_q_ff    <= h_d_ff * scale_s;
      end
      if (state_ff == ST_SAT && out_free) begin
         rsp_found_ff <= found_ff;
         rsp_word_ff  <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_data  = {{(bdbs_pkg::RSP_DATA_W - $bits(bdbs_pkg::rsp_type)){1'b0}}, rsp_word_ff};

endmodule

FILE: hdl/bdbs_checker.sv
// ----------------------------------------------------------------------------
// bdbs_checker
// port-level checks of the result channel of the box selector
// ----------------------------------------------------------------------------
`include "best_detection_box_select_defines.svh"

module bdbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [bdbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   // no result word survives reset
   `BDBS_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

   // a stalled result holds its word
   `BDBS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // an empty frame reports all zeros
   `BDBS_ASSERT(a_empty_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "nonzero fields without a winner")

   // a winner beat a threshold of at least zero, so its confidence is nonzero
   `BDBS_ASSERT(a_winner_conf, rsp_tvalid && rsp_tuser |-> rsp_tdata[bdbs_pkg::CONF_W-1:0] != '0, "winner with zero confidence")

endmodule

bind best_detection_box_select bdbs_checker u_bdbs_checker (.*);
